// ===== hw/rtl/lsos_pkg.sv =====
// ----------------------------------------------------------------------------
// Laser scan object segmenter package
// Shared widths, register indexes, reset values and interface types.
// ----------------------------------------------------------------------------
package lsos_pkg;

    localparam int LSOS_MAX_READINGS = 361;
    localparam int LSOS_QUEUE_DEPTH  = 4;

    localparam int RANGE_W    = 16;
    localparam int IDX_W      = 9;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_DROP   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR_LIMIT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_RISE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_INDEX = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LAST_INDEX  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [RANGE_W-1:0] RST_EDGE_DROP   = 16'd500;
    localparam logic [RANGE_W-1:0] RST_NEAR_LIMIT  = 16'd1000;
    localparam logic [RANGE_W-1:0] RST_EDGE_RISE   = 16'd500;
    localparam logic [IDX_W-1:0]   RST_FIRST_INDEX = 9'd10;
    localparam logic [IDX_W-1:0]   RST_LAST_INDEX  = 9'd350;

    typedef struct packed {
        logic [RANGE_W-1:0] edge_drop;
        logic [RANGE_W-1:0] near_limit;
        logic [RANGE_W-1:0] edge_rise;
        logic [IDX_W-1:0]   first_index;
        logic [IDX_W-1:0]   last_index;
    } lsos_cfg_t;

    // One queue entry holds everything a single reading produces.
    typedef struct packed {
        logic               obj;
        logic [IDX_W-1:0]   center_index;
        logic [RANGE_W-1:0] center_range;
        logic               fin;
    } lsos_entry_t;

endpackage

// ===== hw/rtl/laser_scan_object_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// Laser scan object segmenter
// Finds near objects in a laser range scan and reports their centers.
//
// Input stream: one range reading per request in s_axis_tdata, with tlast on
// the final reading of a scan. Output stream: one request per object found,
// tuser high, carrying the center index in half-degree steps and the stored
// range there; after any object of the final reading, an end-of-scan request
// with tuser low, tlast high and zero data.
// Throughput is one reading per cycle while s_axis_tready is high, set by the
// single write port of the range store. A result passes from the reading that
// causes it through a stage for the store read, the entry queue, and the
// output register. A reading that both closes an object and ends the scan
// gives two results, the object one first. When the receiver stalls, results
// wait in the queue and s_axis_tready drops once the queue is full.
// Reset clears the scan state and loads the default thresholds; the range
// store needs no clearing since only entries of the current scan are read.
// Configuration must be written only while no reading or result is in flight.
// ----------------------------------------------------------------------------
module laser_scan_object_segmenter_unit #(
    parameter int MAX_READINGS = lsos_pkg::LSOS_MAX_READINGS,
    parameter int QUEUE_DEPTH  = lsos_pkg::LSOS_QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsos_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lsos_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lsos_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [15:0] range_mm
    input  logic                                s_axis_tlast,   // scan_end
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lsos_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [8:0] center_index,
                                                                // [24:9] center_range
    output logic                                m_axis_tuser,   // is_object
    output logic                                m_axis_tlast    // last
);
    import lsos_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    lsos_cfg_t      cfg_reg, cfg_next;
    logic           push;
    lsos_entry_t    push_entry;
    logic           pop;
    lsos_entry_t    head;
    logic           not_empty;
    logic [LW-1:0]  q_level;
    lsos_entry_t    out_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_EDGE_DROP:   cfg_next.edge_drop   = cfg_wdata;
                CFG_NEAR_LIMIT:  cfg_next.near_limit  = cfg_wdata;
                CFG_EDGE_RISE:   cfg_next.edge_rise   = cfg_wdata;
                CFG_FIRST_INDEX: cfg_next.first_index = cfg_wdata[IDX_W-1:0];
                CFG_LAST_INDEX:  cfg_next.last_index  = cfg_wdata[IDX_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_drop   <= RST_EDGE_DROP;
            cfg_reg.near_limit  <= RST_NEAR_LIMIT;
            cfg_reg.edge_rise   <= RST_EDGE_RISE;
            cfg_reg.first_index <= RST_FIRST_INDEX;
            cfg_reg.last_index  <= RST_LAST_INDEX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsos_front #(
        .MAX_READINGS (MAX_READINGS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .range_mm   (s_axis_tdata[RANGE_W-1:0]),
        .scan_end   (s_axis_tlast),
        .q_level    (q_level),
        .push       (push),
        .push_entry (push_entry)
    );

    lsos_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .level      (q_level)
    );

    lsos_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .not_empty  (not_empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - IDX_W - RANGE_W){1'b0}},
                           out_item.center_range, out_item.center_index};
    assign m_axis_tuser = out_item.obj;
    assign m_axis_tlast = out_item.fin;

    // A committed entry must always find room in the queue.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_level < LW'(QUEUE_DEPTH)) || pop)
        else $error("queue overflow on push");

    // Every queue entry carries at least one result.
    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_entry.obj || push_entry.fin)
        else $error("empty entry pushed");

    // An object result is never marked as the end of the scan.
    a_obj_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
        else $error("object result flagged last");

endmodule

// ===== hw/rtl/lsos_front.sv =====
// ----------------------------------------------------------------------------
// Segmenter front end
// Accepts readings, stores them, finds opening and closing edges and forms
// one queue entry per reading that closes an object or ends the scan.
// ----------------------------------------------------------------------------
module lsos_front #(
    parameter int MAX_READINGS = lsos_pkg::LSOS_MAX_READINGS,
    parameter int QUEUE_DEPTH  = lsos_pkg::LSOS_QUEUE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lsos_pkg::lsos_cfg_t                   cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [lsos_pkg::RANGE_W-1:0]          range_mm,
    input  logic                                  scan_end,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      q_level,
    output logic                                  push,
    output lsos_pkg::lsos_entry_t                 push_entry
);
    import lsos_pkg::*;

    localparam int IW = $clog2(MAX_READINGS + 1);
    localparam int AW = $clog2(MAX_READINGS);
    localparam int CW = (IW > IDX_W) ? IW : IDX_W;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [RANGE_W-1:0] mem [MAX_READINGS];

    logic [IW-1:0]      idx_reg, idx_next;
    logic [RANGE_W-1:0] prev_reg, prev_next;
    logic               open_reg, open_next;
    logic [AW-1:0]      open_pos_reg, open_pos_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_obj_reg, s1_obj_next;
    logic               s1_fin_reg, s1_fin_next;
    logic [AW-1:0]      s1_center_reg, s1_center_next;
    logic [RANGE_W-1:0] rd_data_reg;

    logic               accept;
    logic               in_scan;
    logic               has_prev;
    logic               store_wr;
    logic [IW-1:0]      pos;
    logic [CW-1:0]      pos_c;
    logic [AW-1:0]      pos_a;
    logic [AW-1:0]      span;
    logic [AW-1:0]      center;
    logic               drop_hit;
    logic               rise_hit;
    logic               open_hit;
    logic               close_hit;

    // An entry in stage one is already committed to the queue.
    assign in_ready = ((LW+1)'(q_level) + (LW+1)'(s1_valid_reg)) < (LW+1)'(QUEUE_DEPTH);
    assign accept   = in_valid & in_ready;

    assign in_scan  = idx_reg < IW'(MAX_READINGS);
    assign has_prev = idx_reg != '0;
    assign store_wr = accept & in_scan;
    assign pos      = idx_reg - IW'(1);
    assign pos_c    = CW'(pos);
    assign pos_a    = pos[AW-1:0];

    // d < -edge_drop and d >= edge_rise, without forming a signed difference
    assign drop_hit = ({1'b0, range_mm} + {1'b0, cfg.edge_drop}) < {1'b0, prev_reg};
    assign rise_hit = {1'b0, range_mm} >= ({1'b0, prev_reg} + {1'b0, cfg.edge_rise});

    assign open_hit = store_wr & has_prev & ~open_reg
                    & (pos_c >= CW'(cfg.first_index)) & (pos_c < CW'(cfg.last_index))
                    & drop_hit & (range_mm < cfg.near_limit);
    assign close_hit = store_wr & has_prev & open_reg & rise_hit;

    assign span   = pos_a - open_pos_reg;
    assign center = open_pos_reg + (span >> 1);

    always_comb
    begin
        idx_next      = idx_reg;
        prev_next     = prev_reg;
        open_next     = open_reg;
        open_pos_next = open_pos_reg;
        if (store_wr)
        begin
            idx_next  = idx_reg + IW'(1);
            prev_next = range_mm;
            if (open_hit)
            begin
                open_next     = 1'b1;
                open_pos_next = pos_a;
            end
            else if (close_hit)
            begin
                open_next = 1'b0;
            end
        end
        if (accept & scan_end)
        begin
            idx_next      = '0;
            prev_next     = '0;
            open_next     = 1'b0;
            open_pos_next = '0;
        end
    end

    assign s1_valid_next  = accept & (close_hit | scan_end);
    assign s1_obj_next    = close_hit;
    assign s1_fin_next    = accept & scan_end;
    assign s1_center_next = close_hit ? center : s1_center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            prev_reg      <= '0;
            open_reg      <= 1'b0;
            open_pos_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s1_obj_reg    <= 1'b0;
            s1_fin_reg    <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            prev_reg      <= prev_next;
            open_reg      <= open_next;
            open_pos_reg  <= open_pos_next;
            s1_valid_reg  <= s1_valid_next;
            s1_obj_reg    <= s1_obj_next;
            s1_fin_reg    <= s1_fin_next;
        end
    end

    // The center always lies below the write address, so the read is never
    // to the entry being written in the same cycle.
    always_ff @(posedge clk)
    begin
        s1_center_reg <= s1_center_next;
        if (store_wr)
        begin
            mem[idx_reg[AW-1:0]] <= range_mm;
        end
        if (close_hit)
        begin
            rd_data_reg <= mem[center];
        end
    end

    assign push                    = s1_valid_reg;
    assign push_entry.obj          = s1_obj_reg;
    assign push_entry.center_index = s1_obj_reg ? IDX_W'(s1_center_reg) : '0;
    assign push_entry.center_range = s1_obj_reg ? rd_data_reg : '0;
    assign push_entry.fin          = s1_fin_reg;

endmodule

// ===== hw/rtl/lsos_queue.sv =====
// ----------------------------------------------------------------------------
// Segmenter entry queue
// Small FIFO that decouples the front end from the result sequencer.
// ----------------------------------------------------------------------------
module lsos_queue #(
    parameter int QUEUE_DEPTH = lsos_pkg::LSOS_QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  lsos_pkg::lsos_entry_t             push_entry,
    input  logic                              pop,
    output lsos_pkg::lsos_entry_t             head,
    output logic                              not_empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  level
);
    import lsos_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    lsos_entry_t    slots [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]  level_reg, level_next;
    logic           do_pop;

    assign do_pop = pop & (level_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push & ~do_pop)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (do_pop & ~push)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assign head      = slots[rd_ptr_reg];
    assign not_empty = level_reg != '0;
    assign level     = level_reg;

endmodule

// ===== hw/rtl/lsos_back.sv =====
// ----------------------------------------------------------------------------
// Segmenter result sequencer
// Turns each queue entry into an object result, an end-of-scan result or
// both, and holds them in the output register while the receiver stalls.
// ----------------------------------------------------------------------------
module lsos_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lsos_pkg::lsos_entry_t   head,
    input  logic                    not_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output lsos_pkg::lsos_entry_t   out_item
);
    import lsos_pkg::*;

    logic           out_valid_reg, out_valid_next;
    lsos_entry_t    out_item_reg, out_item_next;
    logic           phase_reg, phase_next;
    logic           load;
    logic           emit_obj;

    assign load     = ~out_valid_reg | out_ready;
    // The object result of an entry goes out before its end-of-scan result.
    assign emit_obj = head.obj & ~phase_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = not_empty;
            if (not_empty)
            begin
                if (emit_obj)
                begin
                    out_item_next     = head;
                    out_item_next.fin = 1'b0;
                    if (head.fin)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    out_item_next.obj          = 1'b0;
                    out_item_next.center_index = '0;
                    out_item_next.center_range = '0;
                    out_item_next.fin          = 1'b1;
                    phase_next                 = 1'b0;
                    pop                        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== verif/laser_scan_object_segmenter_unit_test.sv =====
// ----------------------------------------------------------------------------
// Laser scan object segmenter testbench
// Streams range scans into the segmenter and predicts every object and
// end-of-scan request in a scoreboard that checks each output request in
// order. A short directed part comes first. Random scans follow under
// several threshold settings and random backpressure on both streams.
// ----------------------------------------------------------------------------
module laser_scan_object_segmenter_unit_test;
    import lsos_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1650;

    class scan_scoreboard;
        lsos_cfg_t          cfg;
        logic [RANGE_W-1:0] ranges [LSOS_MAX_READINGS];
        logic [RANGE_W-1:0] prev_range;
        int unsigned        idx;
        bit                 obj_open;
        int unsigned        open_pos;
        lsos_entry_t        expected_q[$];
        int                 mismatches;
        int                 results_checked;
        int                 objects_checked;

        function new();
            cfg.edge_drop   = RST_EDGE_DROP;
            cfg.near_limit  = RST_NEAR_LIMIT;
            cfg.edge_rise   = RST_EDGE_RISE;
            cfg.first_index = RST_FIRST_INDEX;
            cfg.last_index  = RST_LAST_INDEX;
            mismatches      = 0;
            results_checked = 0;
            objects_checked = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            prev_range = '0;
            idx        = 0;
            obj_open   = 1'b0;
            open_pos   = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            case (addr)
                CFG_EDGE_DROP:   cfg.edge_drop   = value;
                CFG_NEAR_LIMIT:  cfg.near_limit  = value;
                CFG_EDGE_RISE:   cfg.edge_rise   = value;
                CFG_FIRST_INDEX: cfg.first_index = value[IDX_W-1:0];
                CFG_LAST_INDEX:  cfg.last_index  = value[IDX_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        // Predicts the requests that one accepted reading causes.
        function void note_reading(logic [RANGE_W-1:0] rng, logic scan_end);
            int          diff;
            int unsigned pos;
            int unsigned center;
            lsos_entry_t e;
            if (idx < LSOS_MAX_READINGS) begin
                ranges[idx] = rng;
                if (idx >= 1) begin
                    pos  = idx - 1;
                    diff = int'(rng) - int'(prev_range);
                    if (!obj_open) begin
                        if (pos >= cfg.first_index && pos < cfg.last_index &&
                            diff < -int'(cfg.edge_drop) && rng < cfg.near_limit) begin
                            obj_open = 1'b1;
                            open_pos = pos;
                        end
                    end
                    else if (diff >= int'(cfg.edge_rise)) begin
                        center         = open_pos + (pos - open_pos) / 2;
                        e.obj          = 1'b1;
                        e.center_index = center[IDX_W-1:0];
                        e.center_range = ranges[center];
                        e.fin          = 1'b0;
                        expected_q.insert(expected_q.size(), e);
                        obj_open = 1'b0;
                    end
                end
                prev_range = rng;
                idx++;
            end
            if (scan_end) begin
                e     = '0;
                e.fin = 1'b1;
                expected_q.insert(expected_q.size(), e);
                clear_scan();
            end
        endfunction

        function void check_result(logic obj, logic [OUT_DATA_W-1:0] data, logic fin);
            lsos_entry_t           e;
            logic [OUT_DATA_W-1:0] want;
            results_checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected request tuser=%0b tdata=%h tlast=%0b",
                                 obj, data, fin));
                return;
            end
            e    = expected_q.pop_front();
            want = {{(OUT_DATA_W-IDX_W-RANGE_W){1'b0}}, e.center_range, e.center_index};
            if (obj !== e.obj || data !== want || fin !== e.fin)
                report($sformatf({"request %0d: expected obj=%0b idx=%0d range=%0d last=%0b,",
                                  " got obj=%0b idx=%0d range=%0d last=%0b tdata=%h"},
                                 results_checked, e.obj, e.center_index, e.center_range,
                                 e.fin, obj, data[IDX_W-1:0], data[IDX_W+RANGE_W-1:IDX_W],
                                 fin, data));
            else if (e.obj)
                objects_checked++;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [15:0] range_mm
    logic                  s_axis_tlast = 1'b0; // scan_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [8:0] center_index, [24:9] center_range
    logic                  m_axis_tuser;        // is_object
    logic                  m_axis_tlast;        // last

    scan_scoreboard sb;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             items_sent = 0;
    int             scans_sent = 0;
    int             cycle_count = 0;

    laser_scan_object_segmenter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Handshakes are sampled mid-cycle, where every signal is settled.
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d requests outstanding",
                     cycle_count, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_reading(logic [RANGE_W-1:0] rng, logic scan_end);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rng;
        s_axis_tlast  <= scan_end;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        sb.note_reading(rng, scan_end);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_reg(addr, value);
    endtask

    task automatic apply_settings(logic [RANGE_W-1:0] drop, logic [RANGE_W-1:0] near,
                                  logic [RANGE_W-1:0] rise, logic [IDX_W-1:0] first,
                                  logic [IDX_W-1:0] stop);
        write_reg(CFG_EDGE_DROP, drop);
        write_reg(CFG_NEAR_LIMIT, near);
        write_reg(CFG_EDGE_RISE, rise);
        write_reg(CFG_FIRST_INDEX, {{(CFG_DATA_W-IDX_W){1'b0}}, first});
        write_reg(CFG_LAST_INDEX, {{(CFG_DATA_W-IDX_W){1'b0}}, stop});
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle_mode(int mode);
        case (mode)
            1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
            3:       begin send_idle_pct = 21; recv_stall_pct = 21; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // A near reading passes the near limit; a far one sits high enough above
    // any near reading that the step to or from it crosses both thresholds.
    function automatic logic [RANGE_W-1:0] pick_near();
        int lim;
        lim = int'(sb.cfg.near_limit);
        if (lim == 0)
            return RANGE_W'($urandom_range(0, 65535));
        return RANGE_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [RANGE_W-1:0] pick_far();
        int lo;
        lo = int'(sb.cfg.near_limit) + 1 +
             ((sb.cfg.edge_drop > sb.cfg.edge_rise) ? int'(sb.cfg.edge_drop)
                                                     : int'(sb.cfg.edge_rise));
        if (lo > 65535)
            lo = 65535;
        return RANGE_W'($urandom_range(lo, 65535));
    endfunction

    task automatic send_scan(int len);
        bit                 near_mode;
        int                 k;
        logic [RANGE_W-1:0] v;
        near_mode = 1'b0;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 80) begin
                if (near_mode)
                    near_mode = ($urandom_range(0, 99) >= 30);
                else
                    near_mode = ($urandom_range(0, 99) < 20);
                v = near_mode ? pick_near() : pick_far();
            end
            else
                v = RANGE_W'($urandom_range(0, 65535));
            send_reading(v, k == len - 1);
        end
        scans_sent++;
    endtask

    initial
    begin
        int phase;
        int phase_start;
        int len;
        int r;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: a one-reading scan, then an object at the first
        // searched position that closes on the reading that ends the scan.
        send_reading(16'hFFFF, 1'b1);
        repeat (11) send_reading(16'd5000, 1'b0);
        send_reading(16'd200, 1'b0);
        send_reading(16'd200, 1'b0);
        send_reading(16'd800, 1'b1);
        wait_idle();

        // Full search window: opening at position zero, a flat step that
        // does not close, full-scale swings, and an object left open.
        apply_settings(16'd500, 16'd1000, 16'd500, 9'd0, 9'd360);
        send_reading(16'd2000, 1'b0);
        send_reading(16'd100, 1'b0);
        send_reading(16'd100, 1'b0);
        send_reading(16'hFFFF, 1'b0);
        send_reading(16'd0, 1'b0);
        send_reading(16'hFFFF, 1'b1);
        send_reading(16'd5000, 1'b0);
        send_reading(16'd0, 1'b0);
        send_reading(16'd0, 1'b1);

        phase = 0;
        while (items_sent < RANDOM_ITEMS + 25) begin
            wait_idle();
            case (phase)
                0: apply_settings(16'd500, 16'd1000, 16'd500, 9'd0, 9'd360);
                1: apply_settings(16'd0, 16'hFFFF, 16'd0, 9'd0, 9'd360);
                2: apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 9'd360, 9'd0);
                3: apply_settings(RST_EDGE_DROP, RST_NEAR_LIMIT, RST_EDGE_RISE,
                                  RST_FIRST_INDEX, RST_LAST_INDEX);
                4: apply_settings(16'd1200, 16'd30000, 16'd300, 9'd200, 9'd100);
                default:
                    apply_settings(RANGE_W'($urandom_range(0, 3000)),
                                   RANGE_W'($urandom_range(100, 40000)),
                                   RANGE_W'($urandom_range(0, 3000)),
                                   IDX_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                                       : $urandom_range(0, 360)),
                                   IDX_W'(($urandom_range(0, 99) < 70) ? $urandom_range(300, 360)
                                                                       : $urandom_range(0, 360)));
            endcase
            set_idle_mode(phase % 4);
            // A scan longer than the store, searched up to its last position.
            if (phase == 0)
                send_scan(365);
            phase_start = items_sent;
            while (items_sent - phase_start < 150) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    len = $urandom_range(1, 40);
                else if (r < 97)
                    len = $urandom_range(41, 150);
                else
                    len = $urandom_range(340, 370);
                send_scan(len);
            end
            phase++;
        end
        wait_idle();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected requests never arrived", sb.pending()));
        $display("Sent %0d readings in %0d scans over %0d threshold settings.",
                 items_sent, scans_sent + 4, phase + 2);
        $display("Checked %0d output requests, %0d of them objects, %0d mismatches.",
                 sb.results_checked, sb.objects_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/lsos_pkg.sv
hw/rtl/lsos_front.sv
hw/rtl/lsos_queue.sv
hw/rtl/lsos_back.sv
hw/rtl/laser_scan_object_segmenter_unit.sv
verif/laser_scan_object_segmenter_unit_test.sv
